>>> rtl/odm_pkg.sv
// Shared types and constants for the orientation deviation monitor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package odm_pkg;

	localparam int FRAC_BITS   = 4;
	localparam int TIME_BITS   = 32;
	localparam int ANG_W       = 13;
	localparam int DEV_W       = 12;
	localparam int LIMIT_W     = 14;
	localparam int STABLE_W    = 13;
	localparam int HOLD_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int FULL_CIRCLE = 360 << FRAC_BITS;

	typedef enum logic [1:0] {
		FN_SAMPLE  = 2'd0,
		FN_CAPTURE = 2'd1,
		FN_BEGIN   = 2'd2,
		FN_END     = 2'd3
	} func_t;

	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_X    = 2'd1;
	localparam logic [1:0] AXIS_Y    = 2'd2;
	localparam logic [1:0] AXIS_Z    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Z      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WATCHED_AXIS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd5;

	typedef struct packed {
		logic signed [LIMIT_W-1:0] limit_x;
		logic signed [LIMIT_W-1:0] limit_y;
		logic signed [LIMIT_W-1:0] limit_z;
		logic [1:0]                watched_axis;
		logic [STABLE_W-1:0]       stable_limit;
		logic [HOLD_W-1:0]         hold_ms;
	} cfg_t;

	typedef struct packed {
		func_t                func;
		logic [TIME_BITS-1:0] time_ms;
		logic [ANG_W-1:0]     ang_x;
		logic [ANG_W-1:0]     ang_y;
		logic [ANG_W-1:0]     ang_z;
	} item_t;

	typedef struct packed {
		logic [DEV_W-1:0] dev_x;
		logic [DEV_W-1:0] dev_y;
		logic [DEV_W-1:0] dev_z;
		logic             alarm_hit;
		logic [1:0]       alarm_axis;
		logic             exercise_done;
		logic             buzzer_on;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/odm_fold.sv
// Folds the three incoming angles into the range 0 .. full circle - 1.
// Depends on odm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module odm_fold (
	input  wire logic        [odm_pkg::ANG_W-1:0]   angle_x,
	input  wire logic signed [odm_pkg::ANG_W:0]     angle_y,
	input  wire logic signed [odm_pkg::ANG_W:0]     angle_z,
	output logic             [odm_pkg::ANG_W-1:0]   fold_x,
	output logic             [odm_pkg::ANG_W-1:0]   fold_y,
	output logic             [odm_pkg::ANG_W-1:0]   fold_z
);
	import odm_pkg::*;

	localparam logic [ANG_W-1:0]        FULL_U = ANG_W'(FULL_CIRCLE);
	localparam logic signed [ANG_W+1:0] FULL_S = (ANG_W+2)'(FULL_CIRCLE);

	function automatic logic [ANG_W-1:0] fold_signed(input logic signed [ANG_W:0] a);
		logic signed [ANG_W+1:0] t0;
		logic signed [ANG_W+1:0] t1;
		logic signed [ANG_W+1:0] t2;
		logic signed [ANG_W+1:0] t3;
		t0 = {a[ANG_W], a};
		t1 = t0[ANG_W+1] ? t0 + FULL_S : t0;
		t2 = t1[ANG_W+1] ? t1 + FULL_S : t1;
		t3 = (t2 >= FULL_S) ? t2 - FULL_S : t2;
		return t3[ANG_W-1:0];
	endfunction

	always_comb begin
		fold_x = (angle_x >= FULL_U) ? angle_x - FULL_U : angle_x;
		fold_y = fold_signed(angle_y);
		fold_z = fold_signed(angle_z);
	end

endmodule

`default_nettype wire

>>> rtl/odm_track.sv
// Origin, kept angles and stability machine, with the deviation and alarm
// logic that produces one result per stepped item. Depends on odm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module odm_track (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire odm_pkg::item_t item,
	input  wire odm_pkg::cfg_t  cfg,
	output odm_pkg::res_t       res
);
	import odm_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RUN  = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	localparam logic [ANG_W-1:0] FULL_U = ANG_W'(FULL_CIRCLE);

	phase_t               phase_q, phase_n, phase_c;
	logic [ANG_W-1:0]     org_x_q, org_y_q, org_z_q;
	logic [ANG_W-1:0]     last_x_q, last_y_q, last_z_q;
	logic [TIME_BITS-1:0] since_q, since_n;
	logic [ANG_W-1:0]     lx, ly, lz, ox, oy, oz, onx, ony, onz;
	logic [DEV_W-1:0]     dx, dy, dz, dsel;
	logic                 sample, stable, completed, hit;
	logic signed [LIMIT_W-1:0] lim;
	logic [TIME_BITS-1:0] elapsed;

	function automatic logic [DEV_W-1:0] circ_dev(input logic [ANG_W-1:0] a,
			input logic [ANG_W-1:0] o);
		logic [ANG_W-1:0] d;
		logic [ANG_W-1:0] other;
		d = (a >= o) ? a - o : o - a;
		other = FULL_U - d;
		return (d < other) ? d[DEV_W-1:0] : other[DEV_W-1:0];
	endfunction

	always_comb begin
		sample = (item.func == FN_SAMPLE);
		lx = sample ? item.ang_x : last_x_q;
		ly = sample ? item.ang_y : last_y_q;
		lz = sample ? item.ang_z : last_z_q;
		if (item.func == FN_CAPTURE) begin
			ox = last_x_q;
			oy = last_y_q;
			oz = last_z_q;
		end else begin
			ox = org_x_q;
			oy = org_y_q;
			oz = org_z_q;
		end
		case (item.func)
			FN_BEGIN: phase_c = PH_RUN;
			FN_END:   phase_c = PH_IDLE;
			default:  phase_c = phase_q;
		endcase

		dx = circ_dev(lx, ox);
		dy = circ_dev(ly, oy);
		dz = circ_dev(lz, oz);

		stable  = ({1'b0, dx} < cfg.stable_limit) && ({1'b0, dy} < cfg.stable_limit) &&
			({1'b0, dz} < cfg.stable_limit);
		elapsed = item.time_ms - since_q;

		phase_n   = phase_c;
		onx       = ox;
		ony       = oy;
		onz       = oz;
		since_n   = since_q;
		completed = 1'b0;
		if (sample && phase_q != PH_DONE) begin
			if (phase_q == PH_RUN && stable) begin
				if (elapsed > TIME_BITS'(cfg.hold_ms)) begin
					phase_n   = PH_DONE;
					completed = 1'b1;
				end
			end else begin
				onx     = lx;
				ony     = ly;
				onz     = lz;
				since_n = item.time_ms;
			end
		end

		case (cfg.watched_axis)
			AXIS_X: begin
				lim  = cfg.limit_x;
				dsel = dx;
			end
			AXIS_Y: begin
				lim  = cfg.limit_y;
				dsel = dy;
			end
			AXIS_Z: begin
				lim  = cfg.limit_z;
				dsel = dz;
			end
			default: begin
				lim  = cfg.limit_x;
				dsel = dx;
			end
		endcase
		hit = (cfg.watched_axis != AXIS_NONE) && !lim[LIMIT_W-1] &&
			({1'b0, dsel} >= lim[LIMIT_W-2:0]);

		res.dev_x         = dx;
		res.dev_y         = dy;
		res.dev_z         = dz;
		res.alarm_hit     = hit;
		res.alarm_axis    = hit ? cfg.watched_axis : AXIS_NONE;
		res.exercise_done = (phase_n == PH_DONE);
		res.buzzer_on     = hit | completed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			org_x_q  <= '0;
			org_y_q  <= '0;
			org_z_q  <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			last_z_q <= '0;
			since_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			org_x_q  <= onx;
			org_y_q  <= ony;
			org_z_q  <= onz;
			last_x_q <= lx;
			last_y_q <= ly;
			last_z_q <= lz;
			since_q  <= since_n;
		end
	end

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("stability phase lost its one-hot code");

	a_completion_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.buzzer_on && !res.alarm_hit |=> phase_q == PH_DONE)
		else $error("completion signalled without entering the completed phase");

	a_capture_origin: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.func == FN_CAPTURE |=>
			org_x_q == last_x_q && org_y_q == last_y_q && org_z_q == last_z_q)
		else $error("origin does not match kept angles after a capture");

	a_idle_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.func == FN_SAMPLE && phase_q == PH_IDLE |=>
			since_q == $past(item.time_ms))
		else $error("start time not re-captured while idle");

endmodule

`default_nettype wire

>>> rtl/orientation_deviation_monitor.sv
// Top level of the orientation deviation monitor: request handshakes,
// configuration registers, input and result registers. Uses odm_pkg, odm_fold
// and odm_track.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries a command and three Euler angles in 1/16 degree; one
// result comes back per request, with the circular deviation of each axis from
// the stored origin, the alarm flag for the watched axis and the state of the
// stability check. The block takes one request per clock cycle unless the input
// stalls; the folded angles are registered on entry, and deviations, alarm and
// stability update are computed combinationally from that register into the
// result register, which drives the outputs. The input stalls only when both
// registers are full and the receiver is not ready. Configuration writes must
// only be issued while no request is in flight.
module orientation_deviation_monitor (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           func,
	input  wire logic [31:0]                          time_ms,
	input  wire logic [odm_pkg::ANG_W-1:0]            angle_x,
	input  wire logic signed [odm_pkg::ANG_W:0]       angle_y,
	input  wire logic signed [odm_pkg::ANG_W:0]       angle_z,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [odm_pkg::DEV_W-1:0]                 dev_x,
	output logic [odm_pkg::DEV_W-1:0]                 dev_y,
	output logic [odm_pkg::DEV_W-1:0]                 dev_z,
	output logic                                      alarm_hit,
	output logic [1:0]                                alarm_axis,
	output logic                                      exercise_done,
	output logic                                      buzzer_on,
	input  wire logic                                 cfg_we,
	input  wire logic [odm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [odm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import odm_pkg::*;

	cfg_t             cfg_q;
	item_t            item_s1;
	res_t             res_c, res_s2;
	logic             valid_s1, valid_s2;
	logic             adv, s2_free;
	logic [ANG_W-1:0] fx, fy, fz;

	odm_fold u_fold (
		.angle_x (angle_x),
		.angle_y (angle_y),
		.angle_z (angle_z),
		.fold_x  (fx),
		.fold_y  (fy),
		.fold_z  (fz)
	);

	odm_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	assign s2_free  = !valid_s2 || out_ready;
	assign adv      = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_x      <= LIMIT_W'(240);
			cfg_q.limit_y      <= LIMIT_W'(240);
			cfg_q.limit_z      <= LIMIT_W'(240);
			cfg_q.watched_axis <= AXIS_NONE;
			cfg_q.stable_limit <= STABLE_W'(240);
			cfg_q.hold_ms      <= HOLD_W'(4000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIMIT_X:      cfg_q.limit_x      <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_Y:      cfg_q.limit_y      <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_Z:      cfg_q.limit_z      <= cfg_data[LIMIT_W-1:0];
				REG_WATCHED_AXIS: cfg_q.watched_axis <= cfg_data[1:0];
				REG_STABLE_LIMIT: cfg_q.stable_limit <= cfg_data[STABLE_W-1:0];
				REG_HOLD_MS:      cfg_q.hold_ms      <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func    <= func_t'(func);
			item_s1.time_ms <= time_ms[TIME_BITS-1:0];
			item_s1.ang_x   <= fx;
			item_s1.ang_y   <= fy;
			item_s1.ang_z   <= fz;
		end
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid     = valid_s2;
	assign dev_x         = res_s2.dev_x;
	assign dev_y         = res_s2.dev_y;
	assign dev_z         = res_s2.dev_z;
	assign alarm_hit     = res_s2.alarm_hit;
	assign alarm_axis    = res_s2.alarm_axis;
	assign exercise_done = res_s2.exercise_done;
	assign buzzer_on     = res_s2.buzzer_on;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(res_s2))
		else $error("pending result was overwritten");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stalled request dropped from the input register");

	a_alarm_axis: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (alarm_hit == (alarm_axis != AXIS_NONE)))
		else $error("alarm axis inconsistent with alarm flag");

endmodule

`default_nettype wire

>>> tb/orientation_deviation_monitor_tb.sv
// Self-checking testbench for orientation_deviation_monitor: queued requests drive the
// input handshake, an in-bench model of the deviation and stability logic predicts every
// result. Depends on odm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module orientation_deviation_monitor_tb;

	import odm_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int REPORT_MAX  = 10;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 236;
	localparam int RX_BLOCK    = 300;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		EX_IDLE    = 2'd0,
		EX_RUNNING = 2'd1,
		EX_DONE    = 2'd2
	} ex_phase_t;

	typedef struct {
		func_t              op;
		logic [31:0]        stamp;
		logic [ANG_W-1:0]   ax;
		logic signed [13:0] ay;
		logic signed [13:0] az;
	} orient_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            func = '0;
	logic [31:0]           time_ms = '0;
	logic [ANG_W-1:0]      angle_x = '0;
	logic signed [ANG_W:0] angle_y = '0;
	logic signed [ANG_W:0] angle_z = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DEV_W-1:0]      dev_x;
	logic [DEV_W-1:0]      dev_y;
	logic [DEV_W-1:0]      dev_z;
	logic                  alarm_hit;
	logic [1:0]            alarm_axis;
	logic                  exercise_done;
	logic                  buzzer_on;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	orientation_deviation_monitor DUT (.*);

	orient_req_t req_backlog [$];
	res_t        expected_results [$];
	orient_req_t next_req;
	orient_req_t taken_req;
	res_t        seen_res;
	res_t        want_res;

	// Model state and its copy of the registers.
	int          kept_ang [3];
	int          origin_ang [3];
	ex_phase_t   ex_phase;
	logic [31:0] since_ms;
	int          lim_x;
	int          lim_y;
	int          lim_z;
	logic [1:0]  watch_axis;
	int          stable_lim;
	int          hold_lim;

	int          fault_count = 0;
	int          items_queued = 0;
	int          quiet_cycles = 0;
	logic [31:0] clock_ms = 32'd0;
	logic        in_fire = 1'b0;
	int          tx_gap = 0;
	logic        tx_idle_on = 1'b0;
	int          rx_stall = 0;
	logic        rx_idle_on = 1'b0;
	int          rx_block_left = 0;
	int          rx_block_asks = 0;
	int          rx_block_seen = 0;
	int          quota;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int wrap_angle(input int a);
		if (a < 0)
			a += FULL_CIRCLE;
		if (a < 0)
			a += FULL_CIRCLE;
		if (a >= FULL_CIRCLE)
			a -= FULL_CIRCLE;
		return a;
	endfunction

	function automatic int circ_distance(input int a, input int o);
		int d;
		d = a >= o ? a - o : o - a;
		return d < FULL_CIRCLE - d ? d : FULL_CIRCLE - d;
	endfunction

	task automatic predict_deviation(input orient_req_t r);
		int          dev [3];
		int          lim;
		logic        stable;
		logic        hit;
		logic        completed;
		logic [1:0]  axis;
		logic [31:0] elapsed;
		res_t        e;
		hit = 1'b0;
		completed = 1'b0;
		axis = AXIS_NONE;
		case (r.op)
			FN_SAMPLE: begin
				kept_ang[0] = wrap_angle(int'(r.ax));
				kept_ang[1] = wrap_angle(int'(r.ay));
				kept_ang[2] = wrap_angle(int'(r.az));
			end
			FN_CAPTURE: origin_ang = kept_ang;
			FN_BEGIN: ex_phase = EX_RUNNING;
			default: ex_phase = EX_IDLE;
		endcase
		for (int i = 0; i < 3; i++)
			dev[i] = circ_distance(kept_ang[i], origin_ang[i]);
		if (r.op == FN_SAMPLE && ex_phase != EX_DONE) begin
			stable = dev[0] < stable_lim && dev[1] < stable_lim && dev[2] < stable_lim;
			if (ex_phase == EX_RUNNING && stable) begin
				elapsed = r.stamp - since_ms;
				if (elapsed > 32'(hold_lim)) begin
					ex_phase = EX_DONE;
					completed = 1'b1;
				end
			end else begin
				origin_ang = kept_ang;
				since_ms = r.stamp;
			end
		end
		if (watch_axis != AXIS_NONE) begin
			lim = watch_axis == AXIS_X ? lim_x : watch_axis == AXIS_Y ? lim_y : lim_z;
			if (lim >= 0 && dev[int'(watch_axis) - 1] >= lim) begin
				hit = 1'b1;
				axis = watch_axis;
			end
		end
		e.dev_x = DEV_W'(dev[0]);
		e.dev_y = DEV_W'(dev[1]);
		e.dev_z = DEV_W'(dev[2]);
		e.alarm_hit = hit;
		e.alarm_axis = axis;
		e.exercise_done = ex_phase == EX_DONE;
		e.buzzer_on = hit | completed;
		expected_results.push_back(e);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LIMIT_X: lim_x = int'($signed(data[LIMIT_W-1:0]));
			REG_LIMIT_Y: lim_y = int'($signed(data[LIMIT_W-1:0]));
			REG_LIMIT_Z: lim_z = int'($signed(data[LIMIT_W-1:0]));
			REG_WATCHED_AXIS: watch_axis = data[1:0];
			REG_STABLE_LIMIT: stable_lim = int'(data[STABLE_W-1:0]);
			REG_HOLD_MS: hold_lim = int'(data[HOLD_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int lx, input int ly, input int lz,
			input logic [1:0] axis, input int stab, input int hold);
		write_reg(REG_LIMIT_X, CFG_DATA_W'(lx));
		write_reg(REG_LIMIT_Y, CFG_DATA_W'(ly));
		write_reg(REG_LIMIT_Z, CFG_DATA_W'(lz));
		write_reg(REG_WATCHED_AXIS, CFG_DATA_W'(axis));
		write_reg(REG_STABLE_LIMIT, CFG_DATA_W'(stab));
		write_reg(REG_HOLD_MS, CFG_DATA_W'(hold));
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
	endtask

	function automatic int pick_gap();
		return $urandom_range(0, 9) < 7 ? int'($urandom_range(1, 3)) : int'($urandom_range(8, 40));
	endfunction

	function automatic int pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return -1;
		if (r == 1)
			return FULL_CIRCLE;
		if (r < 6)
			return $urandom_range(0, 300);
		return $urandom_range(0, FULL_CIRCLE);
	endfunction

	function automatic int pick_stable();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		if (r == 1)
			return FULL_CIRCLE;
		if (r == 2)
			return 8191;
		return $urandom_range(20, 600);
	endfunction

	function automatic int pick_hold();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		if (r == 1)
			return 65535;
		return $urandom_range(50, 8000);
	endfunction

	// The same kept angle can arrive in several encodings, folded by the block.
	function automatic logic [ANG_W-1:0] alias_x(input int a);
		if (a + FULL_CIRCLE <= 8191 && $urandom_range(0, 3) == 0)
			return ANG_W'(a + FULL_CIRCLE);
		return ANG_W'(a);
	endfunction

	function automatic logic signed [13:0] alias_yz(input int a);
		int r;
		r = $urandom_range(0, 5);
		if (r == 0 && a + FULL_CIRCLE <= 8191)
			return 14'(a + FULL_CIRCLE);
		if (r == 1 && a - 2 * FULL_CIRCLE >= -8192)
			return 14'(a - 2 * FULL_CIRCLE);
		if (r <= 3)
			return 14'(a - FULL_CIRCLE);
		return 14'(a);
	endfunction

	function automatic int near_angle(input int b, input int j);
		return (b + int'($urandom_range(0, 2 * j)) - j + FULL_CIRCLE) % FULL_CIRCLE;
	endfunction

	task automatic queue_req(input func_t op, input logic [31:0] stamp, input logic [ANG_W-1:0] ax,
			input logic signed [13:0] ay, input logic signed [13:0] az);
		orient_req_t r;
		r.op = op;
		r.stamp = stamp;
		r.ax = ax;
		r.ay = ay;
		r.az = az;
		req_backlog.push_back(r);
		items_queued++;
	endtask

	task automatic queue_sample(input int a0, input int a1, input int a2);
		queue_req(FN_SAMPLE, clock_ms, alias_x(a0), alias_yz(a1), alias_yz(a2));
	endtask

	task automatic queue_cmd(input func_t op);
		queue_req(op, $urandom, ANG_W'($urandom), 14'($urandom), 14'($urandom));
	endtask

	task automatic queue_noise();
		queue_req(func_t'($urandom_range(0, 3)), $urandom, ANG_W'($urandom), 14'($urandom),
				14'($urandom));
	endtask

	// One exercise: settle at a base pose, begin, then jitter around it with the odd jolt.
	task automatic queue_exercise();
		int          base [3];
		int          j;
		int          n;
		int          step_max;
		int          ax;
		int          shift;
		logic [31:0] since;
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 3) == 0)
				base[i] = $urandom_range(0, 1) ? int'($urandom_range(0, 15))
						: int'($urandom_range(FULL_CIRCLE - 16, FULL_CIRCLE - 1));
			else
				base[i] = $urandom_range(0, FULL_CIRCLE - 1);
		end
		j = stable_lim > 1 ? int'($urandom_range(0, (stable_lim - 1) / 2)) : 0;
		if (j > 150)
			j = $urandom_range(0, 150);
		step_max = hold_lim / 3 + 2;
		if ($urandom_range(0, 4) == 0)
			clock_ms += $urandom;
		queue_sample(base[0], base[1], base[2]);
		since = clock_ms;
		if ($urandom_range(0, 3) == 0)
			queue_cmd(FN_CAPTURE);
		clock_ms += $urandom_range(0, 50);
		queue_cmd(FN_BEGIN);
		n = $urandom_range(3, 14);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 11))
				0: begin
					ax = $urandom_range(0, 2);
					shift = stable_lim + int'($urandom_range(0, 600));
					if (shift > FULL_CIRCLE / 2)
						shift = FULL_CIRCLE / 2;
					base[ax] = (base[ax] + shift) % FULL_CIRCLE;
					clock_ms += $urandom_range(0, step_max);
					queue_sample(base[0], base[1], base[2]);
					since = clock_ms;
				end
				1: begin
					clock_ms = since + 32'(hold_lim);
					queue_sample(near_angle(base[0], j), near_angle(base[1], j), near_angle(base[2], j));
					clock_ms += 32'd1;
					queue_sample(near_angle(base[0], j), near_angle(base[1], j), near_angle(base[2], j));
				end
				2: queue_cmd(FN_CAPTURE);
				default: begin
					clock_ms += $urandom_range(0, step_max);
					queue_sample(near_angle(base[0], j), near_angle(base[1], j), near_angle(base[2], j));
				end
			endcase
		end
		if ($urandom_range(0, 3) != 0)
			queue_cmd(FN_END);
	endtask

	task automatic settle();
		while (req_backlog.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				next_req = req_backlog.pop_front();
				func <= next_req.op;
				time_ms <= next_req.stamp;
				angle_x <= next_req.ax;
				angle_y <= next_req.ay;
				angle_z <= next_req.az;
				in_valid <= 1'b1;
				tx_gap <= (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_block_left > 0) begin
			rx_block_left <= rx_block_left - 1;
			out_ready <= 1'b0;
		end else if (rx_block_seen != rx_block_asks) begin
			rx_block_seen <= rx_block_asks;
			rx_block_left <= RX_BLOCK - 1;
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			out_ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			rx_stall <= pick_gap() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			taken_req.op = func_t'(func);
			taken_req.stamp = time_ms;
			taken_req.ax = angle_x;
			taken_req.ay = angle_y;
			taken_req.az = angle_z;
			predict_deviation(taken_req);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_res.dev_x = dev_x;
			seen_res.dev_y = dev_y;
			seen_res.dev_z = dev_z;
			seen_res.alarm_hit = alarm_hit;
			seen_res.alarm_axis = alarm_axis;
			seen_res.exercise_done = exercise_done;
			seen_res.buzzer_on = buzzer_on;
			if (expected_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("%0t: result with no request outstanding: dev %0d/%0d/%0d", $realtime,
							dev_x, dev_y, dev_z);
			end else begin
				want_res = expected_results.pop_front();
				if (seen_res.dev_x !== want_res.dev_x || seen_res.dev_y !== want_res.dev_y
						|| seen_res.dev_z !== want_res.dev_z
						|| seen_res.alarm_hit !== want_res.alarm_hit
						|| seen_res.alarm_axis !== want_res.alarm_axis
						|| seen_res.exercise_done !== want_res.exercise_done
						|| seen_res.buzzer_on !== want_res.buzzer_on) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display({"%0t: mismatch, expected dev %0d/%0d/%0d alarm %0b axis %0d ",
								"done %0b buzzer %0b, got dev %0d/%0d/%0d alarm %0b axis %0d ",
								"done %0b buzzer %0b"}, $realtime,
								want_res.dev_x, want_res.dev_y, want_res.dev_z,
								want_res.alarm_hit, want_res.alarm_axis,
								want_res.exercise_done, want_res.buzzer_on,
								seen_res.dev_x, seen_res.dev_y, seen_res.dev_z,
								seen_res.alarm_hit, seen_res.alarm_axis,
								seen_res.exercise_done, seen_res.buzzer_on);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		lim_x = 240;
		lim_y = 240;
		lim_z = 240;
		watch_axis = AXIS_NONE;
		stable_lim = 240;
		hold_lim = 4000;
		kept_ang = '{0, 0, 0};
		origin_ang = '{0, 0, 0};
		ex_phase = EX_IDLE;
		since_ms = 32'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings, with no axis watched.
		queue_req(FN_SAMPLE, 32'd0, 0, 0, 0);
		queue_req(FN_SAMPLE, 32'd10, 5759, 5759, 5759);
		queue_req(FN_SAMPLE, 32'd20, 8191, 8191, 8191);
		queue_req(FN_SAMPLE, 32'd30, 0, -8192, -2880);
		queue_req(FN_SAMPLE, 32'd40, 5760, -1, -5761);
		queue_req(FN_CAPTURE, 32'hFFFF_FFFF, 8191, -8192, 8191);
		queue_req(FN_SAMPLE, 32'd50, 2880, 2880, 0);
		queue_req(FN_BEGIN, 32'd60, 0, 0, 0);
		queue_req(FN_SAMPLE, 32'd100, 2880, 2880, 0);
		queue_req(FN_SAMPLE, 32'd4050, 2880, 2880, 0);
		queue_req(FN_SAMPLE, 32'd4051, 2880, 2880, 0);
		queue_req(FN_SAMPLE, 32'd5000, 0, 0, 2880);
		queue_req(FN_CAPTURE, 32'd5001, 4095, 4095, -4096);
		queue_req(FN_END, 32'd5002, 0, 0, 0);
		queue_req(FN_SAMPLE, 32'hFFFF_FFF0, 100, -100, 300);
		queue_req(FN_BEGIN, 32'hFFFF_FFF8, 0, 0, 0);
		queue_req(FN_SAMPLE, 32'd4000, 100, -100, 300);
		queue_req(FN_BEGIN, 32'd4001, 0, 0, 0);
		queue_req(FN_SAMPLE, 32'd4100, 5000, 5000, 5000);
		queue_req(FN_END, 32'd4101, 8191, 8191, -8192);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			tx_idle_on = phase != 0 && $urandom_range(0, 3) != 0;
			rx_idle_on = phase != 0 && $urandom_range(0, 3) != 0;
			case (phase)
				0: apply_settings(-1, -1, -1, AXIS_X, 0, 0);
				1: apply_settings(0, FULL_CIRCLE, 240, AXIS_Y, FULL_CIRCLE, 65535);
				2: apply_settings(FULL_CIRCLE, 0, -8192, AXIS_Z, 8191, 0);
				3: apply_settings(pick_limit(), pick_limit(), pick_limit(), AXIS_X, 240, 4000);
				default: apply_settings(pick_limit(), pick_limit(), pick_limit(),
						2'($urandom), pick_stable(), pick_hold());
			endcase
			if (phase == 2)
				clock_ms = 32'hFFFF_C000;
			quota = items_queued + PHASE_ITEMS;
			while (items_queued < quota) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 8)) queue_noise();
				end else begin
					queue_exercise();
				end
			end
			// The receiver holds off while requests keep coming, so the block backs up.
			if (phase == 1)
				rx_block_asks++;
			settle();
		end

		if (fault_count == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d failures, %0d results outstanding", fault_count,
					expected_results.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
